// File: hdl/fclim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fclim_pkg
// Shared constants, types and register indexes of the fan curve level limiter.
// ----------------------------------------------------------------------------
package fclim_pkg;

  localparam int CurvePoints = 8;                      // 2..8
  localparam int PtRegs      = 4;                      // two points per register
  localparam int IdxW        = $clog2(CurvePoints);
  localparam int NptsW       = 4;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 56;
  localparam int ValW        = 16;
  localparam int LvlW        = 8;

  // Divider: quotient is at most 255, two quotient bits per cycle.
  localparam int QuoW        = LvlW;
  localparam int DivCycles   = QuoW / 2;
  localparam int DivCntW     = $clog2(DivCycles);
  localparam int DsorW       = ValW + 1 + QuoW - 1;    // 2*den shifted left by 7
  localparam int RemW        = ValW + LvlW + 2;        // 2*t*m + den

  localparam int QueueDepth  = 2;
  localparam int QPtrW       = $clog2(QueueDepth);
  localparam int QCntW       = $clog2(QueueDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE = 3'd0,
    CFG_NPTS   = 3'd1,
    CFG_PTS01  = 3'd2,
    CFG_PTS23  = 3'd3,
    CFG_PTS45  = 3'd4,
    CFG_PTS67  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                             enabled;
    logic [NptsW-1:0]                 npts;
    logic [PtRegs-1:0][CfgDataW-1:0]  pts;
  } cfg_t;

  // One classified item, handed from the front to the back.
  typedef struct packed {
    logic            applied;
    logic            is_div;   // needs the interpolation divide
    logic            raise;
    logic            neg;      // segment level falls
    logic [LvlW-1:0] level;    // direct level, or start level of the segment
    logic [LvlW-1:0] cur;
    logic [ValW-1:0] t;        // distance from segment start, 0..den
    logic [ValW-1:0] den;      // segment width, nonzero when is_div
    logic [LvlW-1:0] mag;      // level swing of the segment
  } entry_t;

  typedef struct packed {
    logic [LvlW-1:0] curve_level;
    logic [LvlW-1:0] limited_level;
    logic            changed;
    logic            curve_applied;
  } res_t;

endpackage

// File: hdl/fclim_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fclim interfaces
// Valid/ready channels for input items, results and configuration writes.
// ----------------------------------------------------------------------------
interface fclim_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] measurement;
  logic [7:0]  current_level;
  logic        limit_direction;

  modport source (output valid, measurement, current_level, limit_direction,
                  input ready);
  modport sink   (input valid, measurement, current_level, limit_direction,
                  output ready);
endinterface

interface fclim_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] curve_level;
  logic [7:0] limited_level;
  logic       changed;
  logic       curve_applied;

  modport source (output valid, curve_level, limited_level, changed, curve_applied,
                  input ready);
  modport sink   (input valid, curve_level, limited_level, changed, curve_applied,
                  output ready);
endinterface

interface fclim_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [55:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/fclim_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fclim_front
// Accepts input transactions, finds the curve segment and classifies the item.
// ----------------------------------------------------------------------------
module fclim_front
  import fclim_pkg::*;
(
  input  cfg_t          cfg_i,
  fclim_in_if.sink      in_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output entry_t        push_entry_o
);

  logic signed [ValW-1:0] pt_val [CurvePoints];
  logic        [LvlW-1:0] pt_lvl [CurvePoints];

  logic [NptsW-1:0]       n;
  logic [NptsW-1:0]       n_m1;
  logic                   applied;
  logic                   hit;
  logic signed [ValW-1:0] x;
  logic signed [ValW-1:0] v0, v1, vf, vl, lo, hi;
  logic        [LvlW-1:0] l0, l1, lf, ll, out_lvl;
  logic signed [ValW:0]   den_s, t_s;
  entry_t                 e;

  always_comb begin
    for (int i = 0; i < CurvePoints; i++) begin
      pt_val[i] = (i % 2 == 1) ? cfg_i.pts[i/2][47:32] : cfg_i.pts[i/2][15:0];
      pt_lvl[i] = (i % 2 == 1) ? cfg_i.pts[i/2][55:48] : cfg_i.pts[i/2][23:16];
    end
  end

  assign x       = in_i.measurement;
  assign n       = (cfg_i.npts > NptsW'(CurvePoints)) ? NptsW'(CurvePoints) : cfg_i.npts;
  assign applied = cfg_i.enabled && (n >= NptsW'(2));
  assign n_m1    = n - NptsW'(1);

  // Segment search: every segment tested at once, first one in point order wins.
  always_comb begin
    hit = 1'b0;
    v0  = pt_val[0];
    v1  = pt_val[1];
    l0  = pt_lvl[0];
    l1  = pt_lvl[1];
    lo  = '0;
    hi  = '0;
    for (int i = CurvePoints - 1; i >= 1; i--) begin
      lo = (pt_val[i-1] < pt_val[i]) ? pt_val[i-1] : pt_val[i];
      hi = (pt_val[i-1] < pt_val[i]) ? pt_val[i]   : pt_val[i-1];
      if ((NptsW'(i) < n) && (x >= lo) && (x <= hi)) begin
        hit = 1'b1;
        v0  = pt_val[i-1];
        v1  = pt_val[i];
        l0  = pt_lvl[i-1];
        l1  = pt_lvl[i];
      end
    end
  end

  // Outside the curve: level of the nearer end point.
  assign vf = pt_val[0];
  assign vl = pt_val[n_m1[IdxW-1:0]];
  assign lf = pt_lvl[0];
  assign ll = pt_lvl[n_m1[IdxW-1:0]];

  always_comb begin
    if (vf < vl) begin
      out_lvl = (x < vf) ? lf : ll;
    end else begin
      out_lvl = (x < vl) ? ll : lf;
    end
  end

  // Orient the segment so that width and distance are both nonnegative.
  always_comb begin
    if (v1 > v0) begin
      den_s = (ValW+1)'(v1) - (ValW+1)'(v0);
      t_s   = (ValW+1)'(x)  - (ValW+1)'(v0);
    end else begin
      den_s = (ValW+1)'(v0) - (ValW+1)'(v1);
      t_s   = (ValW+1)'(v0) - (ValW+1)'(x);
    end
  end

  always_comb begin
    e         = '0;
    e.applied = applied;
    e.raise   = in_i.limit_direction;
    e.cur     = in_i.current_level;
    e.t       = t_s[ValW-1:0];
    e.den     = den_s[ValW-1:0];
    e.neg     = (l1 < l0);
    e.mag     = (l1 < l0) ? (l0 - l1) : (l1 - l0);
    if (!applied) begin
      e.level = in_i.current_level;
    end else if (!hit) begin
      e.level = out_lvl;
    end else begin
      e.level  = l0;
      e.is_div = (v0 != v1);    // zero-width segment takes its first level
    end
  end

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;
  assign push_entry_o = e;

endmodule

// File: hdl/fclim_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fclim_queue
// Small FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module fclim_queue
  import fclim_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  output logic   push_ready_o,
  input  entry_t push_entry_i,
  output logic   pop_valid_o,
  input  logic   pop_ready_i,
  output entry_t pop_entry_o
);

  entry_t             mem_q [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign push_ready_o = (cnt_q != QCntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(do_push) - QCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// File: hdl/fclim_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fclim_back
// Interpolation divider, level limit and output register.
// ----------------------------------------------------------------------------
module fclim_back
  import fclim_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  entry_t      pop_entry_i,
  fclim_out_if.source out_o
);

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_HOLD = 3'b100
  } bk_state_e;

  bk_state_e          st_q, st_d;
  entry_t             ent_q, ent_d;
  logic [RemW-1:0]    rem_q, rem_d;
  logic [DsorW-1:0]   ds_q, ds_d;
  logic [QuoW-1:0]    quo_q, quo_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  res_t               out_q, out_d;

  logic               out_free;
  logic               load_out;
  res_t               res;
  logic [2*LvlW+ValW-LvlW-1:0] prod;
  logic [RemW-1:0]    dividend;
  logic [RemW-1:0]    ds_a, ds_b, r1, r2;
  logic               b1, b2;
  logic [QuoW-1:0]    quo_step;

  function automatic res_t finish(entry_t e, logic [QuoW-1:0] q);
    res_t            r;
    logic [LvlW-1:0] lvl;
    logic            chg;
    lvl = e.is_div ? (e.neg ? e.level - q : e.level + q) : e.level;
    chg = e.raise ? (lvl > e.cur) : (lvl < e.cur);
    r.curve_level   = lvl;
    r.limited_level = chg ? lvl : e.cur;
    r.changed       = chg;
    r.curve_applied = e.applied;
    return r;
  endfunction

  // Rounded quotient as floor(U / 2den): U = 2tm + den for rising segments,
  // 2tm + den - 1 for falling ones (the sign flips the rounding direction).
  assign prod     = pop_entry_i.t * pop_entry_i.mag;
  assign dividend = {1'b0, prod, 1'b0} + RemW'(pop_entry_i.den)
                  - RemW'(pop_entry_i.neg);

  // Two restoring steps per cycle.
  assign ds_a     = RemW'(ds_q);
  assign ds_b     = RemW'(ds_q >> 1);
  assign b1       = (rem_q >= ds_a);
  assign r1       = b1 ? rem_q - ds_a : rem_q;
  assign b2       = (r1 >= ds_b);
  assign r2       = b2 ? r1 - ds_b : r1;
  assign quo_step = {quo_q[QuoW-3:0], b1, b2};

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    st_d        = st_q;
    ent_d       = ent_q;
    rem_d       = rem_q;
    ds_d        = ds_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    pop_ready_o = 1'b0;
    load_out    = 1'b0;
    res         = finish(pop_entry_i, '0);
    unique case (st_q)
      BK_IDLE: begin
        if (pop_valid_i && (pop_entry_i.is_div || out_free)) begin
          pop_ready_o = 1'b1;
          if (pop_entry_i.is_div) begin
            ent_d = pop_entry_i;
            rem_d = dividend;
            ds_d  = {pop_entry_i.den, 1'b0, {(QuoW-1){1'b0}}};
            quo_d = '0;
            cnt_d = '1;
            st_d  = BK_DIV;
          end else begin
            load_out = 1'b1;
          end
        end
      end
      BK_DIV: begin
        rem_d = r2;
        ds_d  = ds_q >> 2;
        quo_d = quo_step;
        cnt_d = cnt_q - DivCntW'(1);
        if (cnt_q == '0) begin
          if (out_free) begin
            load_out = 1'b1;
            res      = finish(ent_q, quo_step);
            st_d     = BK_IDLE;
          end else begin
            st_d = BK_HOLD;
          end
        end
      end
      BK_HOLD: begin
        res = finish(ent_q, quo_q);
        if (out_free) begin
          load_out = 1'b1;
          st_d     = BK_IDLE;
        end
      end
      default: begin
        st_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    rem_q <= rem_d;
    ds_q  <= ds_d;
    quo_q <= quo_d;
    out_q <= out_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.curve_level   = out_q.curve_level;
  assign out_o.limited_level = out_q.limited_level;
  assign out_o.changed       = out_q.changed;
  assign out_o.curve_applied = out_q.curve_applied;

endmodule

// File: hdl/fan_curve_level_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_curve_level_limiter
// Maps a Q8.8 measurement onto a piecewise linear fan curve and limits the
// current fan level to lower-only or raise-only changes.
// ----------------------------------------------------------------------------
//
//  channel | dir | transaction
//  --------+-----+--------------------------------------------------------
//  in_i    | in  | measurement, current_level, limit_direction
//  out_o   | out | curve_level, limited_level, changed, curve_applied
//  cfg_i   | in  | register write: index, data (always ready)
//
//  Front classifies a transaction in the cycle it is accepted and pushes it
//  into a 2-entry queue; in_i is ready whenever the queue has room.
//  Interpolating items are loaded and multiplied, then divided 2 quotient bits
//  per step; others leave the queue at 1 per cycle while the back end is idle and the output register is free.
//  Results sit in an output register; the back end keeps working while a
//  result waits, and stalls only when the next result has nowhere to go.
//  Reset clears config (curve disabled, 0 points), queue and control state.
//
module fan_curve_level_limiter
  import fclim_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  fclim_in_if.sink    in_i,
  fclim_out_if.source out_o,
  fclim_cfg_if.sink   cfg_i
);

  cfg_t   cfg_q, cfg_d;
  logic   push_valid, push_ready;
  entry_t push_entry;
  logic   pop_valid, pop_ready;
  entry_t pop_entry;

  // Config writes land immediately; indexes past the list are dropped.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ENABLE: cfg_d.enabled = cfg_i.data[0];
        CFG_NPTS:   cfg_d.npts    = cfg_i.data[NptsW-1:0];
        CFG_PTS01:  cfg_d.pts[0]  = cfg_i.data;
        CFG_PTS23:  cfg_d.pts[1]  = cfg_i.data;
        CFG_PTS45:  cfg_d.pts[2]  = cfg_i.data;
        CFG_PTS67:  cfg_d.pts[3]  = cfg_i.data;
        default:    cfg_d         = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fclim_front u_front (
    .cfg_i        (cfg_q),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  fclim_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  fclim_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_o       (out_o)
  );

endmodule
